FILE: hdl/ptsc_pkg.sv
`default_nettype none

package ptsc_pkg;

   // Channel count default and the limit that a 3-bit channel field can address
   localparam int CHANNELS_DEF = 8;
   localparam int CH_LIMIT     = 8;

   // Shared divider / multiplier sizes
   localparam int DIV_W = 23;
   localparam int DVS_W = 16;
   localparam int CNT_W = 5;

   localparam logic [CNT_W-1:0] CNT_DIV = 5'd22;
   localparam logic [CNT_W-1:0] CNT_MUL = 5'd6;

   // Request modes
   localparam logic [1:0] MODE_PERIOD = 2'd0;
   localparam logic [1:0] MODE_DUTY   = 2'd1;
   localparam logic [1:0] MODE_TEMP   = 2'd2;
   localparam logic [1:0] MODE_MOTOR  = 2'd3;

   // Response targets
   localparam logic [1:0] TGT_CHANNEL = 2'd0;
   localparam logic [1:0] TGT_FAN     = 2'd1;
   localparam logic [1:0] TGT_MOTOR   = 2'd2;

   // Response actions
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_FULL    = 2'd1;
   localparam logic [1:0] ACT_COMPARE = 2'd2;
   localparam logic [1:0] ACT_REJECT  = 2'd3;

   // CSR indexes
   localparam logic [1:0] REG_FAN_ON    = 2'd0;
   localparam logic [1:0] REG_FAN_OFF   = 2'd1;
   localparam logic [1:0] REG_FAN_DRIVE = 2'd2;

   localparam logic signed [11:0] FAN_ON_RST    = 12'sd450;
   localparam logic signed [11:0] FAN_OFF_RST   = 12'sd400;
   localparam logic [15:0]        FAN_DRIVE_RST = 16'd5000;
   localparam logic [7:0]         MOTOR_RST     = 8'd10;

   // Arithmetic constants
   localparam logic [DIV_W-1:0] FREQ_NUM  = 23'd10000;
   localparam logic [DIV_W-1:0] FAST_NUM  = 23'd1000000;
   localparam logic [DIV_W-1:0] SLOW_NUM  = 23'd100000;
   localparam logic [DVS_W-1:0] SCALE_DIV = 16'd100;

   localparam logic [15:0] FAST_MAX_PERIOD = 16'd500;
   localparam logic [15:0] SLOW_MAX_PERIOD = 16'd5000;
   localparam logic [12:0] PSC_FAST        = 13'd719;
   localparam logic [12:0] PSC_SLOW        = 13'd7199;
   localparam logic [15:0] LEVEL_GAIN      = 16'd216;
   localparam logic [15:0] DUTY_MAX        = 16'd100;
   localparam logic [15:0] LEVEL_MAX       = 16'd255;

   typedef struct packed {
      logic [1:0]         mode;
      logic [2:0]         channel;
      logic [15:0]        value;
      logic signed [11:0] temperature;
   } req_type;

   typedef struct packed {
      logic [1:0]  target;
      logic [2:0]  out_channel;
      logic [1:0]  action;
      logic [12:0] prescaler;
      logic [15:0] reload;
      logic [15:0] compare;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FREQ,
      ST_RELOAD,
      ST_MUL,
      ST_SCALE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: hdl/pwm_timer_setting_calculator.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  ptsc_pkg::req_type (mode, channel, value, temp)
// rsp      out        rsp_valid / rsp_ready  ptsc_pkg::rsp_type (target .. compare)
// csr      in         csr_we                 csr_index, csr_wdata (write only)
//
// A period load that reprograms a channel runs three 23-step passes of the
// bit-serial restoring divider (10000/period, constant/frequency, product/100)
// and a 7-step shift-add multiply by the duty. A duty load runs the multiply
// plus one divide; every other request goes straight to the response.
// A request is taken only while the sequencer is idle; a finished response
// waits in the output register while the next request is taken and worked on.
// Reset is synchronous and active high; it clears the channel stores, the motor
// level and the fan registers to their start values, no clearing pass.
`default_nettype none

module pwm_timer_setting_calculator #(
   parameter int CHANNELS = ptsc_pkg::CHANNELS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ptsc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ptsc_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   // Channels beyond what the 3-bit channel field reaches are never addressed
   localparam int NUM_CH = (CHANNELS > ptsc_pkg::CH_LIMIT) ? ptsc_pkg::CH_LIMIT : CHANNELS;
   localparam int IDX_W  = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
   localparam int DIV_W  = ptsc_pkg::DIV_W;
   localparam int DVS_W  = ptsc_pkg::DVS_W;
   localparam int CNT_W  = ptsc_pkg::CNT_W;

   ptsc_pkg::state_type state_ff, state_in;

   // Per-channel stores, read at the one channel being worked on
   logic [15:0] period_ff [NUM_CH];
   logic [15:0] period_in [NUM_CH];
   logic [6:0]  duty_ff   [NUM_CH];
   logic [6:0]  duty_in   [NUM_CH];
   logic [15:0] reload_ff [NUM_CH];
   logic [15:0] reload_in [NUM_CH];
   logic [7:0]  motor_ff, motor_in;

   logic signed [11:0] fan_on_ff, fan_on_in;
   logic signed [11:0] fan_off_ff, fan_off_in;
   logic [15:0]        fan_drive_ff, fan_drive_in;

   // Sequencer datapath: quo doubles as the multiply accumulator, dvs as the multiplicand
   logic [2:0]       ch_ff, ch_in;
   logic             slow_ff, slow_in;
   logic [6:0]       mplier_ff, mplier_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   ptsc_pkg::rsp_type res_ff, res_in;
   ptsc_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic             req_fire;
   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] cur_idx;
   logic             in_range;
   logic             period_same;
   logic             period_bad;
   logic [6:0]       duty_sat;
   logic             duty_same;
   logic [7:0]       level_sat;
   logic             level_same;

   logic [DVS_W:0]   div_shift;
   logic             div_ge;
   logic [DVS_W:0]   div_diff;
   logic [DIV_W-1:0] div_q;
   logic [DIV_W-1:0] mul_sum;

   assign req_ready = (state_ff == ptsc_pkg::ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Request decode against the stored channel state
   always_comb begin
      req_idx     = req_data.channel[IDX_W-1:0];
      cur_idx     = ch_ff[IDX_W-1:0];
      in_range    = ({1'b0, req_data.channel} < 4'(NUM_CH));
      period_same = (req_data.value == period_ff[req_idx]);
      period_bad  = (req_data.value == 16'd0) || (req_data.value > ptsc_pkg::SLOW_MAX_PERIOD);
      duty_sat    = (req_data.value > ptsc_pkg::DUTY_MAX) ? ptsc_pkg::DUTY_MAX[6:0]
                                                          : req_data.value[6:0];
      duty_same   = (duty_sat == duty_ff[req_idx]);
      level_sat   = (req_data.value > ptsc_pkg::LEVEL_MAX) ? ptsc_pkg::LEVEL_MAX[7:0]
                                                           : req_data.value[7:0];
      level_same  = (level_sat == motor_ff);
   end

   // One restoring-division step and one shift-add multiply step per cycle
   always_comb begin
      div_shift = {rem_ff, quo_ff[DIV_W-1]};
      div_ge    = (div_shift >= {1'b0, dvs_ff});
      div_diff  = div_shift - {1'b0, dvs_ff};
      div_q     = {quo_ff[DIV_W-2:0], div_ge};
      mul_sum   = {quo_ff[DIV_W-2:0], 1'b0} + (mplier_ff[6] ? DIV_W'(dvs_ff) : '0);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptsc_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.mode)
                  ptsc_pkg::MODE_PERIOD: begin
                     if (!in_range || period_same || period_bad) begin
                        state_in = ptsc_pkg::ST_DONE;
                     end else begin
                        state_in = ptsc_pkg::ST_FREQ;
                     end
                  end
                  ptsc_pkg::MODE_DUTY: begin
                     if (!in_range || duty_same) begin
                        state_in = ptsc_pkg::ST_DONE;
                     end else begin
                        state_in = ptsc_pkg::ST_MUL;
                     end
                  end
                  default: state_in = ptsc_pkg::ST_DONE;
               endcase
            end
         end
         ptsc_pkg::ST_FREQ: begin
            if (cnt_ff == '0) state_in = ptsc_pkg::ST_RELOAD;
         end
         ptsc_pkg::ST_RELOAD: begin
            if (cnt_ff == '0) state_in = ptsc_pkg::ST_MUL;
         end
         ptsc_pkg::ST_MUL: begin
            if (cnt_ff == '0) state_in = ptsc_pkg::ST_SCALE;
         end
         ptsc_pkg::ST_SCALE: begin
            if (cnt_ff == '0) state_in = ptsc_pkg::ST_DONE;
         end
         ptsc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ptsc_pkg::ST_IDLE;
         end
         default: state_in = ptsc_pkg::ST_IDLE;
      endcase
   end

   // CSR writes; indexes past the list drop
   always_comb begin
      fan_on_in    = fan_on_ff;
      fan_off_in   = fan_off_ff;
      fan_drive_in = fan_drive_ff;
      if (csr_we) begin
         unique case (csr_index)
            ptsc_pkg::REG_FAN_ON:    fan_on_in    = csr_wdata[11:0];
            ptsc_pkg::REG_FAN_OFF:   fan_off_in   = csr_wdata[11:0];
            ptsc_pkg::REG_FAN_DRIVE: fan_drive_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Datapath and store updates
   always_comb begin
      period_in    = period_ff;
      duty_in      = duty_ff;
      reload_in    = reload_ff;
      motor_in     = motor_ff;
      ch_in        = ch_ff;
      slow_in      = slow_ff;
      mplier_in    = mplier_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff) inside
         ptsc_pkg::ST_IDLE: begin
            if (req_fire) begin
               res_in = '0;
               ch_in  = req_data.channel;
               unique case (req_data.mode)
                  ptsc_pkg::MODE_PERIOD: begin
                     res_in.target      = ptsc_pkg::TGT_CHANNEL;
                     res_in.out_channel = req_data.channel;
                     if (in_range && !period_same) begin
                        period_in[req_idx] = req_data.value;
                        if (period_bad) begin
                           reload_in[req_idx] = '0;
                           res_in.action      = ptsc_pkg::ACT_REJECT;
                        end else begin
                           // frequency = 10000 / period
                           slow_in = (req_data.value > ptsc_pkg::FAST_MAX_PERIOD);
                           rem_in  = '0;
                           quo_in  = ptsc_pkg::FREQ_NUM;
                           dvs_in  = req_data.value;
                           cnt_in  = ptsc_pkg::CNT_DIV;
                        end
                     end
                  end
                  ptsc_pkg::MODE_DUTY: begin
                     res_in.target      = ptsc_pkg::TGT_CHANNEL;
                     res_in.out_channel = req_data.channel;
                     if (in_range && !duty_same) begin
                        duty_in[req_idx] = duty_sat;
                        res_in.action    = ptsc_pkg::ACT_COMPARE;
                        dvs_in           = reload_ff[req_idx];
                        mplier_in        = duty_sat;
                        quo_in           = '0;
                        cnt_in           = ptsc_pkg::CNT_MUL;
                     end
                  end
                  ptsc_pkg::MODE_TEMP: begin
                     // Hysteresis: between the thresholds leave the fan alone
                     res_in.target = ptsc_pkg::TGT_FAN;
                     if ($signed(req_data.temperature) > fan_on_ff) begin
                        res_in.action  = ptsc_pkg::ACT_COMPARE;
                        res_in.compare = fan_drive_ff;
                     end else if ($signed(req_data.temperature) < fan_off_ff) begin
                        res_in.action  = ptsc_pkg::ACT_COMPARE;
                     end
                  end
                  ptsc_pkg::MODE_MOTOR: begin
                     res_in.target = ptsc_pkg::TGT_MOTOR;
                     if (!level_same) begin
                        motor_in       = level_sat;
                        res_in.action  = ptsc_pkg::ACT_COMPARE;
                        res_in.compare = {8'd0, level_sat} * ptsc_pkg::LEVEL_GAIN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ptsc_pkg::ST_FREQ, ptsc_pkg::ST_RELOAD, ptsc_pkg::ST_SCALE: begin
            rem_in = div_ge ? div_diff[DVS_W-1:0] : div_shift[DVS_W-1:0];
            quo_in = div_q;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (state_ff == ptsc_pkg::ST_FREQ) begin
                  // reload = constant / frequency
                  rem_in = '0;
                  quo_in = slow_ff ? ptsc_pkg::SLOW_NUM : ptsc_pkg::FAST_NUM;
                  dvs_in = div_q[DVS_W-1:0];
                  cnt_in = ptsc_pkg::CNT_DIV;
               end else if (state_ff == ptsc_pkg::ST_RELOAD) begin
                  reload_in[cur_idx] = div_q[15:0];
                  res_in.action      = ptsc_pkg::ACT_FULL;
                  res_in.prescaler   = slow_ff ? ptsc_pkg::PSC_SLOW : ptsc_pkg::PSC_FAST;
                  res_in.reload      = div_q[15:0];
                  dvs_in             = div_q[DVS_W-1:0];
                  mplier_in          = duty_ff[cur_idx];
                  quo_in             = '0;
                  cnt_in             = ptsc_pkg::CNT_MUL;
               end else begin
                  res_in.compare = div_q[15:0];
               end
            end
         end
         ptsc_pkg::ST_MUL: begin
            quo_in    = mul_sum;
            mplier_in = {mplier_ff[5:0], 1'b0};
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               // compare = product / 100
               rem_in = '0;
               dvs_in = ptsc_pkg::SCALE_DIV;
               cnt_in = ptsc_pkg::CNT_DIV;
            end
         end
         ptsc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptsc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         motor_ff     <= ptsc_pkg::MOTOR_RST;
         fan_on_ff    <= ptsc_pkg::FAN_ON_RST;
         fan_off_ff   <= ptsc_pkg::FAN_OFF_RST;
         fan_drive_ff <= ptsc_pkg::FAN_DRIVE_RST;
         for (int i = 0; i < NUM_CH; i++) begin
            period_ff[i] <= '0;
            duty_ff[i]   <= '0;
            reload_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         motor_ff     <= motor_in;
         fan_on_ff    <= fan_on_in;
         fan_off_ff   <= fan_off_in;
         fan_drive_ff <= fan_drive_in;
         period_ff    <= period_in;
         duty_ff      <= duty_in;
         reload_ff    <= reload_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      slow_ff     <= slow_in;
      mplier_ff   <= mplier_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dvs_ff      <= dvs_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Divider remainder stays below the divisor through every pass
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptsc_pkg::ST_FREQ || state_ff == ptsc_pkg::ST_RELOAD ||
       state_ff == ptsc_pkg::ST_SCALE) |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.action == ptsc_pkg::ACT_FULL) |->
      ((rsp_data_ff.prescaler == ptsc_pkg::PSC_FAST ||
        rsp_data_ff.prescaler == ptsc_pkg::PSC_SLOW) &&
       rsp_data_ff.reload != 16'd0 && rsp_data_ff.compare <= rsp_data_ff.reload))
      else $error("full reprogram with bad prescaler, reload or compare");

   a_partial_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.action != ptsc_pkg::ACT_FULL) |->
      (rsp_data_ff.prescaler == 13'd0 && rsp_data_ff.reload == 16'd0))
      else $error("prescaler or reload set without full reprogram");

   a_side_channel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.target != ptsc_pkg::TGT_CHANNEL) |->
      (rsp_data_ff.out_channel == 3'd0))
      else $error("fan or motor response carries a channel");

endmodule

`default_nettype wire

FILE: test/pwm_timer_setting_calculator_test.sv
`timescale 1ns / 100ps

module pwm_timer_setting_calculator_test;
   import ptsc_pkg::*;

   // Cycles in a row with no request, response or register write before giving up.
   // The slowest request is a period reload, and each side draws its waits from
   // draw_wait, so this leaves a wide margin.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 100;
   localparam int DIRECTED_ROWS  = 26;
   // Quiet time after the last response; covers one full period reload.
   localparam int TAIL_CYCLES    = 100;

   // One directed row: the request, whether its response is typed in here, and
   // that response. Rows that are not pinned are checked against the predictor.
   typedef struct packed {
      req_type stim;
      bit      pinned;
      rsp_type want;
   } table_row_type;

   localparam table_row_type DIRECTED [DIRECTED_ROWS] = '{
      // period equal to the stored one right after reset: nothing to do
      '{'{MODE_PERIOD, 3'd0, 16'd0, 12'sd0}, 1'b1, '{TGT_CHANNEL, 3'd0, ACT_NONE, 13'd0, 16'd0, 16'd0}},
      // shortest period: 10 kHz, fast prescaler, duty still zero
      '{'{MODE_PERIOD, 3'd0, 16'd1, 12'sd0}, 1'b1, '{TGT_CHANNEL, 3'd0, ACT_FULL, 13'd719, 16'd100, 16'd0}},
      '{'{MODE_DUTY, 3'd0, 16'd100, 12'sd0}, 1'b1, '{TGT_CHANNEL, 3'd0, ACT_COMPARE, 13'd0, 16'd0, 16'd100}},
      // duty saturates to 100, same as stored
      '{'{MODE_DUTY, 3'd0, 16'hFFFF, 12'sd0}, 1'b1, '{TGT_CHANNEL, 3'd0, ACT_NONE, 13'd0, 16'd0, 16'd0}},
      // period of zero is rejected and clears the reload
      '{'{MODE_PERIOD, 3'd0, 16'd0, 12'sd0}, 1'b1, '{TGT_CHANNEL, 3'd0, ACT_REJECT, 13'd0, 16'd0, 16'd0}},
      '{'{MODE_DUTY, 3'd0, 16'd50, 12'sd0}, 1'b1, '{TGT_CHANNEL, 3'd0, ACT_COMPARE, 13'd0, 16'd0, 16'd0}},
      // 20 Hz and 19 Hz: the border between the two prescalers
      '{'{MODE_PERIOD, 3'd1, 16'd500, 12'sd0}, 1'b1, '{TGT_CHANNEL, 3'd1, ACT_FULL, 13'd719, 16'd50000, 16'd0}},
      '{'{MODE_PERIOD, 3'd1, 16'd501, 12'sd0}, 1'b0, '0},
      // 2 Hz and 1 Hz: lowest accepted frequency and the first one rejected
      '{'{MODE_PERIOD, 3'd2, 16'd5000, 12'sd0}, 1'b1, '{TGT_CHANNEL, 3'd2, ACT_FULL, 13'd7199, 16'd50000, 16'd0}},
      '{'{MODE_PERIOD, 3'd2, 16'd5001, 12'sd0}, 1'b1, '{TGT_CHANNEL, 3'd2, ACT_REJECT, 13'd0, 16'd0, 16'd0}},
      '{'{MODE_PERIOD, 3'd3, 16'hFFFF, 12'sd0}, 1'b1, '{TGT_CHANNEL, 3'd3, ACT_REJECT, 13'd0, 16'd0, 16'd0}},
      '{'{MODE_DUTY, 3'd1, 16'd37, 12'sd0}, 1'b0, '0},
      '{'{MODE_PERIOD, 3'd1, 16'd250, 12'sd0}, 1'b0, '0},
      '{'{MODE_DUTY, 3'd7, 16'd0, 12'sd0}, 1'b1, '{TGT_CHANNEL, 3'd7, ACT_NONE, 13'd0, 16'd0, 16'd0}},
      '{'{MODE_DUTY, 3'd7, 16'd101, 12'sd0}, 1'b1, '{TGT_CHANNEL, 3'd7, ACT_COMPARE, 13'd0, 16'd0, 16'd0}},
      '{'{MODE_PERIOD, 3'd7, 16'd2, 12'sd0}, 1'b0, '0},
      // fan hysteresis around the reset thresholds; the channel field is ignored
      '{'{MODE_TEMP, 3'd5, 16'hFFFF, 12'sd451}, 1'b1, '{TGT_FAN, 3'd0, ACT_COMPARE, 13'd0, 16'd0, 16'd5000}},
      '{'{MODE_TEMP, 3'd0, 16'd0, 12'sd450}, 1'b1, '{TGT_FAN, 3'd0, ACT_NONE, 13'd0, 16'd0, 16'd0}},
      '{'{MODE_TEMP, 3'd7, 16'd0, 12'sd400}, 1'b1, '{TGT_FAN, 3'd0, ACT_NONE, 13'd0, 16'd0, 16'd0}},
      '{'{MODE_TEMP, 3'd0, 16'd0, 12'sd399}, 1'b1, '{TGT_FAN, 3'd0, ACT_COMPARE, 13'd0, 16'd0, 16'd0}},
      '{'{MODE_TEMP, 3'd2, 16'd0, 12'sh800}, 1'b1, '{TGT_FAN, 3'd0, ACT_COMPARE, 13'd0, 16'd0, 16'd0}},
      '{'{MODE_TEMP, 3'd0, 16'd0, 12'sh7FF}, 1'b1, '{TGT_FAN, 3'd0, ACT_COMPARE, 13'd0, 16'd0, 16'd5000}},
      // motor: unchanged level, saturation above 255, and zero
      '{'{MODE_MOTOR, 3'd4, 16'd10, 12'sh7FF}, 1'b1, '{TGT_MOTOR, 3'd0, ACT_NONE, 13'd0, 16'd0, 16'd0}},
      '{'{MODE_MOTOR, 3'd0, 16'hFFFF, 12'sd0}, 1'b1, '{TGT_MOTOR, 3'd0, ACT_COMPARE, 13'd0, 16'd0, 16'd55080}},
      '{'{MODE_MOTOR, 3'd0, 16'd300, 12'sd0}, 1'b1, '{TGT_MOTOR, 3'd0, ACT_NONE, 13'd0, 16'd0, 16'd0}},
      '{'{MODE_MOTOR, 3'd3, 16'd0, 12'sd0}, 1'b1, '{TGT_MOTOR, 3'd0, ACT_COMPARE, 13'd0, 16'd0, 16'd0}}
   };

   // Periods on and around the frequency borders; also make repeats likely.
   localparam logic [15:0] PERIOD_MARKS [10] = '{
      16'd0, 16'd1, 16'd2, 16'd499, 16'd500, 16'd501, 16'd4999, 16'd5000, 16'd5001, 16'hFFFF
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Travels with the request so the monitor knows which expectation to use.
   bit         req_pinned = 1'b0;
   rsp_type    req_pinned_want = '0;

   // Predictor copy of the channel stores, motor level and fan registers.
   logic [15:0]        period_mem [8];
   logic [6:0]         duty_mem [8];
   logic [15:0]        reload_mem [8];
   logic [7:0]         motor_now;
   logic signed [11:0] fan_on_t;
   logic signed [11:0] fan_off_t;
   logic [15:0]        fan_drive;

   rsp_type pending_settings [$];
   int      num_issued = 0;
   int      num_settled = 0;
   int      mismatch_count = 0;
   int      idle_cycles = 0;
   int      stall_left = 0;
   bit      req_calm = 1'b0;
   bit      rsp_calm = 1'b0;

   always #5 clock = ~clock;

   pwm_timer_setting_calculator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Draw a random wait length. Now and then flip into a calm stretch where
   // every wait is zero, so back-to-back traffic gets exercised as well.
   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 24) == 0) calm = !calm;
      return calm ? 0 : int'($urandom_range(0, 14));
   endfunction

   // Work out the timer write for one request and advance the stored state.
   function automatic rsp_type calc_timer_setting(input req_type r);
      rsp_type     res;
      logic [2:0]  ch;
      int unsigned freq;
      int unsigned rld;
      int unsigned d;
      int unsigned lvl;
      res = '0;
      ch  = r.channel;
      rld = 0;
      case (r.mode)
         MODE_PERIOD: begin
            res.target      = TGT_CHANNEL;
            res.out_channel = ch;
            if (r.value != period_mem[ch]) begin
               period_mem[ch] = r.value;
               freq = (r.value == 16'd0) ? 0 : 10000 / int'(r.value);
               if (freq >= 20 && freq <= 10000) begin
                  res.prescaler = 13'd719;
                  rld = 1000000 / freq;
               end else if (freq >= 2 && freq < 20) begin
                  res.prescaler = 13'd7199;
                  rld = 100000 / freq;
               end
               reload_mem[ch] = 16'(rld);
               // every accepted frequency gives a reload of at least 100
               if (rld == 0) begin
                  res.action = ACT_REJECT;
               end else begin
                  res.action  = ACT_FULL;
                  res.reload  = 16'(rld);
                  res.compare = 16'(rld * duty_mem[ch] / 100);
               end
            end
         end
         MODE_DUTY: begin
            res.target      = TGT_CHANNEL;
            res.out_channel = ch;
            d = (r.value > 16'd100) ? 100 : int'(r.value);
            if (d != duty_mem[ch]) begin
               duty_mem[ch] = 7'(d);
               res.action   = ACT_COMPARE;
               res.compare  = 16'(d * reload_mem[ch] / 100);
            end
         end
         MODE_TEMP: begin
            res.target = TGT_FAN;
            if ($signed(r.temperature) > fan_on_t) begin
               res.action  = ACT_COMPARE;
               res.compare = fan_drive;
            end else if ($signed(r.temperature) < fan_off_t) begin
               res.action  = ACT_COMPARE;
            end
         end
         MODE_MOTOR: begin
            res.target = TGT_MOTOR;
            lvl = (r.value > 16'd255) ? 255 : int'(r.value);
            if (lvl != motor_now) begin
               motor_now   = 8'(lvl);
               res.action  = ACT_COMPARE;
               res.compare = 16'(lvl * 216);
            end
         end
      endcase
      return res;
   endfunction

   // Random request. Fields the mode ignores stay fully random; the used field
   // leans toward borders and small ranges so that repeats (unchanged period,
   // duty or level) and threshold hits come up often.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick          = $urandom_range(0, 19);
      r.mode        = (pick < 7) ? MODE_PERIOD : (pick < 13) ? MODE_DUTY :
                      (pick < 17) ? MODE_TEMP : MODE_MOTOR;
      r.channel     = 3'($urandom);
      r.value       = 16'($urandom);
      r.temperature = 12'($urandom);
      pick          = $urandom_range(0, 9);
      case (r.mode)
         MODE_PERIOD: begin
            if (pick < 3)      r.value = 16'($urandom_range(1, 500));
            else if (pick < 6) r.value = 16'($urandom_range(501, 5000));
            else if (pick < 9) r.value = PERIOD_MARKS[$urandom_range(0, 9)];
         end
         MODE_DUTY: begin
            if (pick < 7)      r.value = 16'($urandom_range(0, 110));
            else if (pick < 9) r.value = (pick == 7) ? 16'd0 : 16'd100;
         end
         MODE_TEMP: begin
            if (pick < 3)      r.temperature = fan_on_t + 12'($urandom_range(0, 4)) - 12'sd2;
            else if (pick < 6) r.temperature = fan_off_t + 12'($urandom_range(0, 4)) - 12'sd2;
            else if (pick < 8) r.temperature = 12'($urandom_range(0, 1650)) - 12'sd400;
         end
         MODE_MOTOR: begin
            if (pick < 5)      r.value = 16'($urandom_range(0, 12));
            else if (pick < 8) r.value = 16'($urandom_range(250, 300));
         end
      endcase
      return r;
   endfunction

   // Present one request after a random gap and hold it until it is taken.
   // Valid is only dropped when a gap follows, so a back-to-back request never
   // sees valid lowered and raised in the same step.
   task automatic send_request(input req_type item, input bit pinned, input rsp_type want);
      int gap;
      gap = draw_wait(req_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         req_data  <= random_request();
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data        <= item;
      req_pinned      <= pinned;
      req_pinned_want <= want;
      do @(posedge clock); while (!req_ready);
      num_issued++;
   endtask

   // Drop valid, hold off until every response is back, then let the block settle.
   task automatic hold_until_settled();
      req_valid <= 1'b0;
      while (num_settled < num_issued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all three fan registers on consecutive cycles.
   task automatic set_fan_registers(input logic [15:0] on_v, input logic [15:0] off_v,
                                    input logic [15:0] drive_v);
      csr_we    <= 1'b1;
      csr_index <= REG_FAN_ON;
      csr_wdata <= on_v;
      @(posedge clock);
      csr_index <= REG_FAN_OFF;
      csr_wdata <= off_v;
      @(posedge clock);
      csr_index <= REG_FAN_DRIVE;
      csr_wdata <= drive_v;
      @(posedge clock);
      csr_we    <= 1'b0;
      csr_wdata <= 16'($urandom);
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Response side: after each response, stall ready for a random number of cycles.
   always @(posedge clock) begin : rsp_side
      int stall;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         stall = draw_wait(rsp_calm);
         rsp_ready  <= (stall == 0);
         stall_left <= stall;
      end else if (!rsp_ready) begin
         if (stall_left <= 1) rsp_ready <= 1'b1;
         stall_left <= stall_left - 1;
      end
   end

   // Monitor: mirror register writes, predict on each accepted request, check
   // each accepted response against the oldest expectation, and run the
   // watchdog. Everything here samples the values from just before the edge.
   always @(posedge clock) begin : observe
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            period_mem[i] = '0;
            duty_mem[i]   = '0;
            reload_mem[i] = '0;
         end
         motor_now = 8'd10;
         fan_on_t  = 12'sd450;
         fan_off_t = 12'sd400;
         fan_drive = 16'd5000;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_FAN_ON:    fan_on_t  = csr_wdata[11:0];
               REG_FAN_OFF:   fan_off_t = csr_wdata[11:0];
               REG_FAN_DRIVE: fan_drive = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            // run the predictor even for pinned rows to keep its state in step
            want = calc_timer_setting(req_data);
            if (req_pinned) want = req_pinned_want;
            pending_settings.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_settings.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_data);
               mismatch_count++;
            end else begin
               want = pending_settings.pop_front();
               check_field("target", want.target, rsp_data.target);
               check_field("out_channel", want.out_channel, rsp_data.out_channel);
               check_field("action", want.action, rsp_data.action);
               check_field("prescaler", want.prescaler, rsp_data.prescaler);
               check_field("reload", want.reload, rsp_data.reload);
               check_field("compare", want.compare, rsp_data.compare);
            end
            num_settled++;
         end
         if (csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Stimulus: directed table at reset settings, then random phases. Each phase
   // after the first waits for the block to drain and reprograms the fan
   // registers, extremes included.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_request(DIRECTED[i].stim, DIRECTED[i].pinned, DIRECTED[i].want);

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            hold_until_settled();
            case (p)
               // band covers every temperature: the fan never changes
               1: set_fan_registers(16'h07FF, 16'h0800, 16'hFFFF);
               // inverted band: every sample switches the fan
               2: set_fan_registers(16'h0800, 16'h07FF, 16'h0000);
               3: set_fan_registers(16'd1250, 16'(-400), 16'd40000);
               // junk in the upper bits of the threshold writes is dropped
               4: set_fan_registers(16'($urandom), 16'($urandom), 16'($urandom));
               default: set_fan_registers(16'd0, 16'd0, 16'd1);
            endcase
         end
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_request(random_request(), 1'b0, '0);
      end

      hold_until_settled();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_settings.size() != 0) begin
         $error("%0d responses never arrived", pending_settings.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
hdl/ptsc_pkg.sv
hdl/pwm_timer_setting_calculator.sv
test/pwm_timer_setting_calculator_test.sv
